FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands. Clock clk_i and active-low reset rst_ni are assumed.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lgpm_pkg.sv
// ----------------------------------------------------------------------------
// lgpm_pkg
// Shared constants, config codes and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package lgpm_pkg;

  localparam int COORD_BITS_DEF = 18;
  localparam int RINGS          = 16;
  localparam int RING_W         = 4;
  localparam int COL_W          = 11;
  localparam int IDX_W          = 15;
  localparam int SLOPE_W        = 16;
  localparam int TOP_W          = 4;
  localparam int Q_SHIFT        = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SLOPE_SQ = 1'b0;
  localparam cfg_idx_t CFG_TOP_RING = 1'b1;

  localparam logic [SLOPE_W-1:0] SLOPE_RST = 16'd2038;
  localparam logic [TOP_W-1:0]   TOP_RST   = 4'd4;

  // shared multiplier operand select
  typedef enum logic [1:0] {
    SEL_DX,
    SEL_DY,
    SEL_DZ,
    SEL_H
  } mul_sel_e;

  typedef struct packed {
    logic     in_load;   // capture point, update previous point
    mul_sel_e sel;
    logic     h_init;    // h = dx^2
    logic     h_acc;     // h += dy^2
    logic     dz_load;   // dz2 = dz^2
    logic     rhs_load;  // rhs = slope * h
    logic     out_load;  // write result register
  } cmd_t;

  typedef struct packed {
    logic elig;      // incoming point forms a checked pair
    logic out_free;  // result register can take a beat
  } sts_t;

endpackage

`default_nettype wire

FILE: hdl/lgpm_if.sv
// ----------------------------------------------------------------------------
// lgpm_if
// Point input channel and pair result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgpm_point_if
  import lgpm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic        [RING_W-1:0]     ring;
  logic        [COL_W-1:0]      column;
  logic signed [COORD_BITS-1:0] x_mm;
  logic signed [COORD_BITS-1:0] y_mm;
  logic signed [COORD_BITS-1:0] z_mm;

  modport source (output valid, ring, column, x_mm, y_mm, z_mm, input ready);
  modport sink   (input valid, ring, column, x_mm, y_mm, z_mm, output ready);
endinterface

interface lgpm_result_if
  import lgpm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             pair_checked;
  logic             is_ground;
  logic [IDX_W-1:0] lower_index;
  logic [IDX_W-1:0] upper_index;

  modport source (output valid, pair_checked, is_ground, lower_index, upper_index,
                  input ready);
  modport sink   (input valid, pair_checked, is_ground, lower_index, upper_index,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/lgpm_ctrl.sv
// ----------------------------------------------------------------------------
// lgpm_ctrl
// Sequencer: one shared multiplier over dx^2, dy^2, dz^2, slope*h.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lgpm_ctrl
  import lgpm_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MX   = 3'd1;
  localparam logic [2:0] ST_MY   = 3'd2;
  localparam logic [2:0] ST_MZ   = 3'd3;
  localparam logic [2:0] ST_MS   = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_WB) && sts_i.out_free);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.sel     = SEL_DX;
    cmd_o.in_load = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = sts_i.elig ? ST_MX : ST_WB;
        end
      end
      ST_MX: begin
        cmd_o.sel    = SEL_DX;
        cmd_o.h_init = 1'b1;
        state_d      = ST_MY;
      end
      ST_MY: begin
        cmd_o.sel   = SEL_DY;
        cmd_o.h_acc = 1'b1;
        state_d     = ST_MZ;
      end
      ST_MZ: begin
        cmd_o.sel     = SEL_DZ;
        cmd_o.dz_load = 1'b1;
        state_d       = ST_MS;
      end
      ST_MS: begin
        cmd_o.sel      = SEL_H;
        cmd_o.rhs_load = 1'b1;
        state_d        = ST_WB;
      end
      ST_WB: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (accept) begin
            state_d = sts_i.elig ? ST_MX : ST_WB;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NOW(a_load_needs_room, cmd_o.out_load, sts_i.out_free, "result written while full")
  `ASSERT_NEXT(a_pair_starts_mul, accept && sts_i.elig, state_q == ST_MX,
               "checked pair did not start multiply sequence")
  `ASSERT_NOW(a_accept_when_free, accept, (state_q == ST_IDLE) || cmd_o.out_load,
              "point taken while busy")

endmodule

`default_nettype wire

FILE: hdl/lgpm_dp.sv
// ----------------------------------------------------------------------------
// lgpm_dp
// Datapath: previous point, config, shared multiplier, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lgpm_dp
  import lgpm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
)(
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0]        cfg_data_i,
  input  wire  [RING_W-1:0]            ring_i,
  input  wire  [COL_W-1:0]             column_i,
  input  wire  signed [COORD_BITS-1:0] x_i,
  input  wire  signed [COORD_BITS-1:0] y_i,
  input  wire  signed [COORD_BITS-1:0] z_i,
  input  wire  cmd_t                   cmd_i,
  output sts_t                         sts_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         pair_checked_o,
  output logic                         is_ground_o,
  output logic [IDX_W-1:0]             lower_index_o,
  output logic [IDX_W-1:0]             upper_index_o
);

  localparam int DW  = COORD_BITS + 1;                   // |diff| width
  localparam int SQW = 2 * DW;                           // square width
  localparam int HW  = SQW + 1;                          // dx^2 + dy^2
  localparam int BW  = (DW > SLOPE_W) ? DW : SLOPE_W;    // mult B operand
  localparam int PW  = HW + BW;                          // product width

  function automatic logic [DW-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                             input logic [COORD_BITS-1:0] b);
    logic signed [DW-1:0] d;
    d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  // config
  logic [SLOPE_W-1:0] slope_q;
  logic [TOP_W-1:0]   top_q;

  // previous point
  logic                  prev_valid_q;
  logic [RING_W-1:0]     prev_ring_q;
  logic [COL_W-1:0]      prev_col_q;
  logic [COORD_BITS-1:0] prev_x_q, prev_y_q, prev_z_q;

  // work registers
  logic             elig_q;
  logic [DW-1:0]    dx_q, dy_q, dz_q;
  logic [IDX_W-1:0] lo_idx_q, up_idx_q;
  logic [HW-1:0]    h_q;
  logic [SQW-1:0]   dz2_q;
  logic [PW-1:0]    rhs_q;

  // result register
  logic             out_valid_q;
  logic             checked_q, ground_q;
  logic [IDX_W-1:0] lower_q, upper_q;

  logic             elig;
  logic [IDX_W-1:0] lo_idx, up_idx;
  logic [HW-1:0]    mul_a;
  logic [BW-1:0]    mul_b;
  logic [PW-1:0]    prod;
  logic [PW-1:0]    lhs;
  logic             out_free;

  assign elig = prev_valid_q && (column_i == prev_col_q) &&
                ({1'b0, ring_i} == ({1'b0, prev_ring_q} + (RING_W+1)'(1))) &&
                (ring_i <= top_q);

  assign lo_idx = IDX_W'(IDX_W'(prev_col_q) * IDX_W'(RINGS) + IDX_W'(prev_ring_q));
  assign up_idx = IDX_W'(IDX_W'(column_i) * IDX_W'(RINGS) + IDX_W'(ring_i));

  always_comb begin
    unique case (cmd_i.sel)
      SEL_DX: begin
        mul_a = HW'(dx_q);
        mul_b = BW'(dx_q);
      end
      SEL_DY: begin
        mul_a = HW'(dy_q);
        mul_b = BW'(dy_q);
      end
      SEL_DZ: begin
        mul_a = HW'(dz_q);
        mul_b = BW'(dz_q);
      end
      SEL_H: begin
        mul_a = h_q;
        mul_b = BW'(slope_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);
  // dz^2 * 2^16
  assign lhs  = PW'({dz2_q, Q_SHIFT'(0)});

  assign out_free       = !out_valid_q || out_ready_i;
  assign sts_o.elig     = elig;
  assign sts_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q      <= SLOPE_RST;
      top_q        <= TOP_RST;
      prev_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SLOPE_SQ: slope_q <= cfg_data_i[SLOPE_W-1:0];
          CFG_TOP_RING: top_q   <= cfg_data_i[TOP_W-1:0];
          default:      ;
        endcase
      end
      if (cmd_i.in_load) begin
        prev_valid_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      prev_ring_q <= ring_i;
      prev_col_q  <= column_i;
      prev_x_q    <= x_i;
      prev_y_q    <= y_i;
      prev_z_q    <= z_i;
      elig_q      <= elig;
      dx_q        <= abs_diff(x_i, prev_x_q);
      dy_q        <= abs_diff(y_i, prev_y_q);
      dz_q        <= abs_diff(z_i, prev_z_q);
      lo_idx_q    <= elig ? lo_idx : '0;
      up_idx_q    <= elig ? up_idx : '0;
    end
    if (cmd_i.h_init) begin
      h_q <= HW'(prod);
    end else if (cmd_i.h_acc) begin
      h_q <= h_q + HW'(prod);
    end
    if (cmd_i.dz_load) begin
      dz2_q <= SQW'(prod);
    end
    if (cmd_i.rhs_load) begin
      rhs_q <= prod;
    end
    if (cmd_i.out_load) begin
      checked_q <= elig_q;
      ground_q  <= elig_q && (lhs <= rhs_q);
      lower_q   <= lo_idx_q;
      upper_q   <= up_idx_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pair_checked_o = checked_q;
  assign is_ground_o    = ground_q;
  assign lower_index_o  = lower_q;
  assign upper_index_o  = upper_q;

  `ASSERT_NEXT(a_load_sets_valid, cmd_i.out_load, out_valid_q, "result beat lost")
  `ASSERT_NOW(a_ground_is_checked, out_valid_q && ground_q, checked_q,
              "ground flag without checked pair")

endmodule

`default_nettype wire

FILE: hdl/lidar_ground_pair_marking.sv
// Sequence: a checked pair runs MX, MY, MZ, MS, then WB writes its result beat
//   when the result register is free; other points go straight to WB instead,
//   giving an all-zero result. New points are taken only in IDLE or as WB writes,
//   so a checked pair holds the input through four shared-multiplier passes.
// Reset: clears controller, previous-point valid and result valid; config goes
//   to slope 2038 (10 deg) and top ring 4. No clearing pass.
// ----------------------------------------------------------------------------
// lidar_ground_pair_marking
// Marks adjacent-ring point pairs in one column as ground when the slope test
// dz^2 * 2^16 <= slope_sq * (dx^2 + dy^2) holds.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_ground_pair_marking
  import lgpm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
)(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // config write port
  input  wire                    cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0]  cfg_data_i,
  // point beats in, result beats out
  lgpm_point_if.sink             pt_i,
  lgpm_result_if.source          res_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // sequencer: decides per point whether the multiply passes run
  lgpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pt_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign pt_i.ready = in_ready;

  // datapath: previous point, diffs, shared multiplier, result register
  lgpm_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .ring_i         (pt_i.ring),
    .column_i       (pt_i.column),
    .x_i            (pt_i.x_mm),
    .y_i            (pt_i.y_mm),
    .z_i            (pt_i.z_mm),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (res_o.valid),
    .out_ready_i    (res_o.ready),
    .pair_checked_o (res_o.pair_checked),
    .is_ground_o    (res_o.is_ground),
    .lower_index_o  (res_o.lower_index),
    .upper_index_o  (res_o.upper_index)
  );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar ground-pair marker. Point beats go in
// with random gaps while the result side stalls at random. Every accepted
// point is run through a local model of the pair test. Each result beat is
// checked against the oldest predicted result. The run moves through several
// register settings, the extremes among them.
// ----------------------------------------------------------------------------

module tb_top;
  import lgpm_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int CYCLE_LIMIT = 1_000_000;
  // extra wait after every predicted result has come back
  localparam int SETTLE      = 8;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

  typedef struct packed {
    logic [RING_W-1:0] ring;
    logic [COL_W-1:0]  column;
    coord_t            x_mm;
    coord_t            y_mm;
    coord_t            z_mm;
  } point_t;

  typedef struct packed {
    logic             checked;
    logic             ground;
    logic [IDX_W-1:0] lower;
    logic [IDX_W-1:0] upper;
  } pair_result_t;

  // --------------------------------------------------------------------------
  // Pair predictor and result store
  // --------------------------------------------------------------------------
  class pair_scoreboard;
    logic [SLOPE_W-1:0] slope;
    logic [TOP_W-1:0]   top_ring;
    bit                 have_prev;
    point_t             prev;
    pair_result_t       pending_q[$];
    int                 errors;

    function new();
      slope     = SLOPE_RST;
      top_ring  = TOP_RST;
      have_prev = 0;
      prev      = '0;
      errors    = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_SLOPE_SQ: slope = d[SLOPE_W-1:0];
        CFG_TOP_RING: top_ring = d[TOP_W-1:0];
        default: ;
      endcase
    endfunction

    // Predict the result of one accepted point and remember it as previous.
    function void note_point(point_t p);
      pair_result_t e;
      longint       dx, dy, dz, horiz_sq, lhs, rhs;
      e = '0;
      if (have_prev && p.column == prev.column &&
          int'(p.ring) == int'(prev.ring) + 1 && p.ring <= top_ring) begin
        dx       = longint'($signed(p.x_mm)) - longint'($signed(prev.x_mm));
        dy       = longint'($signed(p.y_mm)) - longint'($signed(prev.y_mm));
        dz       = longint'($signed(p.z_mm)) - longint'($signed(prev.z_mm));
        horiz_sq = dx * dx + dy * dy;
        // dz^2 * 2^16 <= slope * (dx^2 + dy^2), worst case ~2^53, fits
        lhs      = (dz * dz) <<< Q_SHIFT;
        rhs      = longint'(slope) * horiz_sq;
        e.checked = 1'b1;
        e.ground  = (lhs <= rhs);
        e.lower   = IDX_W'(int'(prev.column) * RINGS + int'(prev.ring));
        e.upper   = IDX_W'(int'(p.column) * RINGS + int'(p.ring));
      end
      pending_q.insert(pending_q.size(), e);
      prev      = p;
      have_prev = 1;
    endfunction

    function void check_result(pair_result_t got);
      pair_result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected result beat: chk=%0b gnd=%0b lo=%0d up=%0d",
                   $time, got.checked, got.ground, got.lower, got.upper);
      end else begin
        e = pending_q.pop_front();
        if (got !== e) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch chk/gnd/lo/up exp %0b/%0b/%0d/%0d got %0b/%0b/%0d/%0d",
                     $time, e.checked, e.ground, e.lower, e.upper,
                     got.checked, got.ground, got.lower, got.upper);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lgpm_point_if  pt_bus();
  lgpm_result_if res_bus();

  pair_scoreboard sb = new();

  // calm = 1: no gaps on the point side, no stalls on the result side
  bit calm;
  int stall_left;

  lidar_ground_pair_marking i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pt_i       (pt_bus),
    .res_o      (res_bus)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // global watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Idle length: mostly short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random backpressure, check at the rising edge
  // --------------------------------------------------------------------------
  initial begin
    res_bus.ready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_bus.ready = 1'b0;
        stall_left--;
      end else begin
        res_bus.ready = 1'b1;
        if (!calm && $urandom_range(0, 99) < 30)
          stall_left = pick_idle();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready)
      sb.check_result('{checked: res_bus.pair_checked, ground: res_bus.is_ground,
                        lower: res_bus.lower_index, upper: res_bus.upper_index});
  end

  // --------------------------------------------------------------------------
  // Drivers. All tasks start and end right after a falling edge.
  // --------------------------------------------------------------------------
  function automatic point_t mk(int ring, int col, int x, int y, int z);
    point_t p;
    p.ring   = RING_W'(ring);
    p.column = COL_W'(col);
    p.x_mm   = coord_t'(x);
    p.y_mm   = coord_t'(y);
    p.z_mm   = coord_t'(z);
    return p;
  endfunction

  // One point beat. valid stays high across back-to-back beats.
  task automatic send_point(point_t p);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) >= 55)
      gap = pick_idle();
    if (gap > 0) begin
      pt_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pt_bus.valid  = 1'b1;
    pt_bus.ring   = p.ring;
    pt_bus.column = p.column;
    pt_bus.x_mm   = p.x_mm;
    pt_bus.y_mm   = p.y_mm;
    pt_bus.z_mm   = p.z_mm;
    do @(posedge clk); while (!pt_bus.ready);
    sb.note_point(p);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted beat has come back.
  task automatic wait_idle();
    pt_bus.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = d;
    sb.set_register(idx, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Upper data bits of the ring register are junk on purpose.
  task automatic configure(int slope, int top);
    logic [CFG_DATA_W-1:0] d;
    wait_idle();
    write_register(CFG_SLOPE_SQ, CFG_DATA_W'(slope));
    d = CFG_DATA_W'($urandom);
    d[TOP_W-1:0] = TOP_W'(top);
    write_register(CFG_TOP_RING, d);
  endtask

  // Mostly upward column scans with plausible slopes, plus noise points.
  task automatic run_random(int n);
    int     sent, len, r0, k, bx, by, bz, dx, dy, dz, span;
    int     col;
    point_t p;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 75) begin
        col  = ($urandom_range(0, 9) == 0) ? $urandom_range(1800, 2047)
                                           : $urandom_range(0, 1799);
        len  = $urandom_range(2, 16);
        r0   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        bx   = int'($urandom_range(0, 60000)) - 30000;
        by   = int'($urandom_range(0, 60000)) - 30000;
        bz   = int'($urandom_range(0, 4000)) - 2000;
        for (k = 0; k < len && r0 + k <= 15; k++) begin
          if ($urandom_range(0, 19) == 0) begin
            // full-range coordinates
            p = mk(r0 + k, col, $urandom, $urandom, $urandom);
          end else begin
            dx   = int'($urandom_range(0, 3000)) - 1500;
            dy   = int'($urandom_range(0, 3000)) - 1500;
            span = ((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy);
            if ($urandom_range(0, 9) == 0)
              dz = int'($urandom_range(0, 6000)) - 3000;
            else
              dz = int'($urandom_range(0, span / 2 + 4)) - (span / 4 + 2);
            bx += dx;
            by += dy;
            bz += dz;
            p = mk(r0 + k, col, bx, by, bz);
          end
          // broken sequence: skipped ring or foreign column
          if ($urandom_range(0, 29) == 0)
            p.ring = RING_W'($urandom);
          if ($urandom_range(0, 29) == 0)
            p.column = COL_W'($urandom);
          send_point(p);
          sent++;
        end
      end else begin
        send_point(mk($urandom, $urandom, $urandom, $urandom, $urandom));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    calm          = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_SLOPE_SQ;
    cfg_data      = '0;
    pt_bus.valid  = 1'b0;
    pt_bus.ring   = '0;
    pt_bus.column = '0;
    pt_bus.x_mm   = '0;
    pt_bus.y_mm   = '0;
    pt_bus.z_mm   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: slope 2038, top ring 4
    send_point(mk(1, 0, 0, 0, 0));                // first point: never a pair
    send_point(mk(0, 5, 1000, 0, 0));
    send_point(mk(1, 5, 2000, 0, 176));           // just inside 10 deg
    send_point(mk(2, 5, 3000, 0, 353));           // just outside
    send_point(mk(3, 5, 3000, 0, 353));           // vertical, dz = 0
    send_point(mk(4, 5, 3000, 0, 354));           // vertical, dz = 1
    send_point(mk(5, 5, 3100, 0, 354));           // above top ring
    send_point(mk(15, 7, 10, 10, 10));
    send_point(mk(0, 7, 20, 20, 10));             // no wrap from 15 to 0
    send_point(mk(1, 8, 30, 20, 10));             // other column
    send_point(mk(3, 8, 40, 20, 10));             // ring skipped
    send_point(mk(0, 9, -131072, -131072, -131072));
    send_point(mk(1, 9, 131071, 131071, 131071));
    send_point(mk(2, 9, -131072, 131071, -131072));

    // zero slope: only flat pairs pass
    configure(0, 15);
    send_point(mk(14, 2047, 5, 5, -7));
    send_point(mk(15, 2047, -9, 100, -7));
    send_point(mk(0, 1800, 0, 0, 0));
    send_point(mk(1, 1800, 50, 50, 1));

    // widest slope
    configure(65535, 15);
    send_point(mk(0, 3, 131071, -131072, 0));
    send_point(mk(1, 3, -131072, 131071, 131071));
    send_point(mk(2, 3, -131072, 131071, -131072));

    // top ring zero: nothing is ever checked
    configure(2038, 0);
    send_point(mk(0, 4, 100, 0, 0));
    send_point(mk(1, 4, 200, 0, 0));

    // random part over a spread of settings
    configure($urandom_range(0, 65535), $urandom_range(1, 15));
    run_random(300);
    configure(0, 15);
    run_random(250);
    calm = 1'b1;
    configure(65535, 15);
    run_random(200);
    calm = 1'b0;
    configure(2038, 1);
    run_random(200);
    configure($urandom_range(0, 65535), 0);
    run_random(100);
    configure($urandom_range(0, 8000), $urandom_range(1, 15));
    run_random(350);
    calm = 1'b1;
    configure($urandom_range(0, 65535), $urandom_range(1, 15));
    run_random(150);
    calm = 1'b0;
    run_random(150);

    wait_idle();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
